// ===== hdl/led_frame_rotate_blink_controller_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LED_FRAME_ROTATE_BLINK_CONTROLLER_MACROS_SVH
`define LED_FRAME_ROTATE_BLINK_CONTROLLER_MACROS_SVH

// cond must hold at every clock edge out of reset
`define LFRB_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lfrb check failed");

// cons must hold in the same cycle as ante
`define LFRB_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfrb check failed");

// cons must hold in the cycle after ante
`define LFRB_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfrb check failed");

`endif

// ===== hdl/lfrb_pkg.sv =====
// Shared types and constants of the LED frame rotate/blink controller.
package lfrb_pkg;

    localparam int NUM_LEDS      = 256;
    localparam int BYTES_PER_LED = 3;
    localparam int FRAME_BYTES   = NUM_LEDS * BYTES_PER_LED;

    localparam int LED_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam int FILL_W = $clog2(FRAME_BYTES + 1);

    localparam int CMD_W   = 3;
    localparam int MODE_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int IVAL_W  = 16;
    localparam int POS_W   = 10;

    // wide enough for position + 3 * offset without overflow
    localparam int SUM_W = ((POS_W > ADDR_W) ? POS_W : ADDR_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_START      = 3'd0,
        CMD_FEED       = 3'd1,
        CMD_FINISH     = 3'd2,
        CMD_TICK       = 3'd3,
        CMD_RESET_IDLE = 3'd4,
        CMD_SET_BLINK  = 3'd5,
        CMD_SET_ROTATE = 3'd6,
        CMD_READ       = 3'd7
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE      = 3'd0,
        MODE_LOADING   = 3'd1,
        MODE_SENDING   = 3'd2,
        MODE_ROTATING  = 3'd3,
        MODE_BLINK_ON  = 3'd4,
        MODE_BLINK_OFF = 3'd5,
        MODE_RELOAD    = 3'd6,
        MODE_DONE      = 3'd7
    } mode_t;

endpackage

// ===== hdl/led_frame_rotate_blink_controller.sv =====
// LED frame controller: frame memory, mode machine, rotate and blink timing.
//
// One command beat in, one result beat out. Every command but read has its
// result registered when taken; a read goes on through the ST_READ state,
// as the single-port memory's read is registered. The frame memory is
// written by feed and read by read, never both in one cycle. A finished
// result sits in the output register, and the next command is taken in the
// same cycle that result is taken. Rotation is kept as an LED offset added to
// the read address; clearing and blanking are kept as a fill count and a flag,
// so the memory needs no clearing pass after reset or start.
module led_frame_rotate_blink_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [lfrb_pkg::CMD_W-1:0]    command,
    input  logic [lfrb_pkg::BYTE_W-1:0]   data_byte,
    input  logic [lfrb_pkg::IVAL_W-1:0]   period_ms,
    input  logic [lfrb_pkg::POS_W-1:0]    position,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lfrb_pkg::mode_t               mode,
    output logic                          frame_shown,
    output logic [lfrb_pkg::BYTE_W-1:0]   read_data,
    output logic                          is_done,
    output logic                          reload_needed
);
    import lfrb_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_READ
    } state_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [FILL_W-1:0]   fill_count_reg, fill_count_next;
    logic                blanked_reg, blanked_next;
    logic [LED_W-1:0]    rotate_offset_reg, rotate_offset_next;
    logic [IVAL_W-1:0]   blink_period_reg, blink_period_next;
    logic [IVAL_W-1:0]   rotate_period_reg, rotate_period_next;
    logic [IVAL_W-1:0]   elapsed_reg, elapsed_next;
    logic                rd_zero_reg, rd_zero_next;

    logic                res_valid_reg, res_valid_next;
    mode_t               res_mode_reg, res_mode_next;
    logic                res_shown_reg, res_shown_next;
    logic [BYTE_W-1:0]   res_data_reg, res_data_next;

    logic [BYTE_W-1:0]   frame_mem [FRAME_BYTES];
    logic [BYTE_W-1:0]   rd_q_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;

    logic                accept;
    cmd_t                cmd;
    logic                shown;
    logic [IVAL_W-1:0]   elapsed_inc;
    logic [SUM_W-1:0]    pos_ext;
    logic [SUM_W-1:0]    off_ext;
    logic [SUM_W-1:0]    phys_sum;
    logic [SUM_W-1:0]    phys_mod;
    logic                pos_in_range;

    assign cmd_ready = (state_reg == ST_RUN) && (!res_valid_reg || res_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign cmd       = cmd_t'(command);

    assign elapsed_inc = (elapsed_reg == {IVAL_W{1'b1}}) ? elapsed_reg
                                                          : elapsed_reg + 1'b1;

    // displayed position -> physical byte address, one conditional subtract
    assign pos_ext      = SUM_W'(position);
    assign off_ext      = SUM_W'(rotate_offset_reg);
    assign phys_sum     = pos_ext + (off_ext << 1) + off_ext;
    assign phys_mod     = (phys_sum >= SUM_W'(FRAME_BYTES))
                          ? phys_sum - SUM_W'(FRAME_BYTES) : phys_sum;
    assign pos_in_range = pos_ext < SUM_W'(FRAME_BYTES);

    always_comb
    begin
        state_next         = state_reg;
        mode_next          = mode_reg;
        fill_count_next    = fill_count_reg;
        blanked_next       = blanked_reg;
        rotate_offset_next = rotate_offset_reg;
        blink_period_next  = blink_period_reg;
        rotate_period_next = rotate_period_reg;
        elapsed_next       = elapsed_reg;
        rd_zero_next       = rd_zero_reg;
        res_valid_next     = res_valid_reg;
        res_mode_next      = res_mode_reg;
        res_shown_next     = res_shown_reg;
        res_data_next      = res_data_reg;
        mem_we             = 1'b0;
        mem_addr           = phys_mod[ADDR_W-1:0];
        shown              = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        // ST_READ state of a read: memory data is now registered
        if (state_reg == ST_READ)
        begin
            state_next     = ST_RUN;
            res_valid_next = 1'b1;
            res_mode_next  = mode_reg;
            res_shown_next = 1'b0;
            res_data_next  = rd_zero_reg ? '0 : rd_q_reg;
        end

        if (accept)
        begin
            unique case (cmd)
                CMD_START:
                begin
                    fill_count_next    = '0;
                    rotate_offset_next = '0;
                    blanked_next       = 1'b0;
                    mode_next          = MODE_LOADING;
                end
                CMD_FEED:
                begin
                    if (mode_reg == MODE_LOADING && fill_count_reg < FILL_W'(FRAME_BYTES))
                    begin
                        mem_we          = 1'b1;
                        mem_addr        = fill_count_reg[ADDR_W-1:0];
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                end
                CMD_FINISH:
                begin
                    if (mode_reg == MODE_LOADING)
                    begin
                        mode_next = MODE_SENDING;
                    end
                end
                CMD_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    unique case (mode_reg)
                        MODE_SENDING:
                        begin
                            shown = 1'b1;
                            if (rotate_period_reg != '0)
                            begin
                                elapsed_next = '0;
                                mode_next    = MODE_ROTATING;
                            end
                            else if (blink_period_reg != '0)
                            begin
                                elapsed_next = '0;
                                mode_next    = MODE_BLINK_ON;
                            end
                            else
                            begin
                                mode_next = MODE_DONE;
                            end
                        end
                        MODE_ROTATING:
                        begin
                            if (rotate_period_reg == '0)
                            begin
                                mode_next = MODE_DONE;
                            end
                            else if (elapsed_inc >= rotate_period_reg)
                            begin
                                shown        = 1'b1;
                                elapsed_next = '0;
                                rotate_offset_next =
                                    (rotate_offset_reg == LED_W'(NUM_LEDS - 1))
                                    ? '0 : rotate_offset_reg + 1'b1;
                            end
                        end
                        MODE_BLINK_ON:
                        begin
                            if (elapsed_inc >= blink_period_reg)
                            begin
                                shown        = 1'b1;
                                blanked_next = 1'b1;
                                elapsed_next = '0;
                                mode_next    = MODE_BLINK_OFF;
                            end
                        end
                        MODE_BLINK_OFF:
                        begin
                            if (elapsed_inc >= blink_period_reg)
                            begin
                                mode_next = MODE_RELOAD;
                            end
                        end
                        MODE_IDLE, MODE_LOADING, MODE_RELOAD, MODE_DONE:
                        begin
                        end
                    endcase
                end
                CMD_RESET_IDLE:
                begin
                    mode_next = MODE_IDLE;
                end
                CMD_SET_BLINK:
                begin
                    blink_period_next  = period_ms;
                    rotate_period_next = '0;
                    if (period_ms != '0)
                    begin
                        if (mode_reg == MODE_IDLE || mode_reg == MODE_DONE ||
                            mode_reg == MODE_ROTATING)
                        begin
                            elapsed_next = '0;
                            mode_next    = MODE_BLINK_ON;
                        end
                        else if (mode_reg == MODE_BLINK_OFF || mode_reg == MODE_RELOAD)
                        begin
                            mode_next = MODE_RELOAD;
                        end
                    end
                    else if (mode_reg == MODE_BLINK_ON || mode_reg == MODE_BLINK_OFF ||
                             mode_reg == MODE_RELOAD)
                    begin
                        mode_next = MODE_RELOAD;
                    end
                end
                CMD_SET_ROTATE:
                begin
                    rotate_period_next = period_ms;
                    blink_period_next  = '0;
                    if (period_ms != '0)
                    begin
                        if (mode_reg == MODE_IDLE || mode_reg == MODE_DONE ||
                            mode_reg == MODE_BLINK_ON || mode_reg == MODE_ROTATING)
                        begin
                            elapsed_next = '0;
                            mode_next    = MODE_ROTATING;
                        end
                        else if (mode_reg == MODE_BLINK_OFF || mode_reg == MODE_RELOAD)
                        begin
                            mode_next = MODE_RELOAD;
                        end
                    end
                end
                CMD_READ:
                begin
                    state_next   = ST_READ;
                    rd_zero_next = blanked_reg || !pos_in_range ||
                                   (phys_mod >= SUM_W'(fill_count_reg));
                end
            endcase

            if (cmd != CMD_READ)
            begin
                res_valid_next = 1'b1;
                res_mode_next  = mode_next;
                res_shown_next = shown;
                res_data_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_RUN;
            mode_reg          <= MODE_IDLE;
            fill_count_reg    <= '0;
            blanked_reg       <= 1'b0;
            rotate_offset_reg <= '0;
            blink_period_reg  <= '0;
            rotate_period_reg <= '0;
            elapsed_reg       <= '0;
            rd_zero_reg       <= 1'b0;
            res_valid_reg     <= 1'b0;
            res_mode_reg      <= MODE_IDLE;
            res_shown_reg     <= 1'b0;
            res_data_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            mode_reg          <= mode_next;
            fill_count_reg    <= fill_count_next;
            blanked_reg       <= blanked_next;
            rotate_offset_reg <= rotate_offset_next;
            blink_period_reg  <= blink_period_next;
            rotate_period_reg <= rotate_period_next;
            elapsed_reg       <= elapsed_next;
            rd_zero_reg       <= rd_zero_next;
            res_valid_reg     <= res_valid_next;
            res_mode_reg      <= res_mode_next;
            res_shown_reg     <= res_shown_next;
            res_data_reg      <= res_data_next;
        end
    end

    // single-port frame memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= data_byte;
        end
        rd_q_reg <= frame_mem[mem_addr];
    end

    assign res_valid     = res_valid_reg;
    assign mode          = res_mode_reg;
    assign frame_shown   = res_shown_reg;
    assign read_data     = res_data_reg;
    assign is_done       = (res_mode_reg == MODE_DONE);
    assign reload_needed = (res_mode_reg == MODE_RELOAD);

endmodule

// ===== hdl/lfrb_checker.sv =====
// Port-level checker for the LED frame controller, bound to the top level.
`include "led_frame_rotate_blink_controller_macros.svh"

module lfrb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_ready,
    input  logic [lfrb_pkg::CMD_W-1:0]    command,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  lfrb_pkg::mode_t               mode,
    input  logic                          frame_shown,
    input  logic [lfrb_pkg::BYTE_W-1:0]   read_data,
    input  logic                          is_done,
    input  logic                          reload_needed
);
    import lfrb_pkg::*;

    `LFRB_ALWAYS(a_flags_match_mode, !res_valid || ((is_done == (mode == MODE_DONE)) && (reload_needed == (mode == MODE_RELOAD))))

    // a pushed frame always lands in a running or finished mode
    `LFRB_IMPLIES(a_shown_mode, res_valid && frame_shown, mode == MODE_ROTATING || mode == MODE_BLINK_ON || mode == MODE_BLINK_OFF || mode == MODE_DONE)

    // start always answers in the next cycle with loading
    `LFRB_NEXT(a_start_loads, cmd_valid && cmd_ready && command == CMD_START, res_valid && mode == MODE_LOADING && !frame_shown && read_data == '0)

    `LFRB_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(mode) && $stable(read_data) && $stable(frame_shown))

endmodule

bind led_frame_rotate_blink_controller lfrb_checker u_lfrb_checker (.*);

// ===== tb/tb_led_frame_rotate_blink_controller.sv =====
// Self-checking testbench for the LED frame rotate/blink controller.
module tb_led_frame_rotate_blink_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import lfrb_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEM_TARGET  = 1450;

    typedef struct {
        mode_t      mode;
        logic       shown;
        logic [7:0] rd;
        logic       done;
        logic       reload;
    } result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_ready;
    cmd_t              command = CMD_START;
    logic [BYTE_W-1:0] data_byte = '0;
    logic [IVAL_W-1:0] period_ms = '0;
    logic [POS_W-1:0]  position = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    mode_t             mode;
    logic              frame_shown;
    logic [BYTE_W-1:0] read_data;
    logic              is_done;
    logic              reload_needed;

    // controller state as the checker sees it
    mode_t       ctl_mode = MODE_IDLE;
    logic [7:0]  frame_copy [FRAME_BYTES];
    int unsigned ctl_fill = 0;
    bit          ctl_blank = 0;
    int unsigned ctl_offset = 0;
    logic [15:0] blink_iv = '0;
    logic [15:0] rotate_iv = '0;
    logic [15:0] elapsed = '0;

    result_t pending_results [$];
    int      live_items = 0;
    int      result_beats = 0;
    int      fail_cnt = 0;
    int      gap_pct = 0;
    int      stall_pct = 0;

    led_frame_rotate_blink_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .command       (command),
        .data_byte     (data_byte),
        .period_ms     (period_ms),
        .position      (position),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .mode          (mode),
        .frame_shown   (frame_shown),
        .read_data     (read_data),
        .is_done       (is_done),
        .reload_needed (reload_needed)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] displayed_byte(int unsigned pos);
        int unsigned phys;
        if (pos >= FRAME_BYTES || ctl_blank)
            return 8'h00;
        phys = (pos + BYTES_PER_LED * ctl_offset) % FRAME_BYTES;
        if (phys >= ctl_fill)
            return 8'h00;
        return frame_copy[phys];
    endfunction

    // one millisecond plus one run step; returns 1 when the frame goes out
    function automatic bit run_tick();
        if (elapsed != 16'hFFFF)
            elapsed++;
        case (ctl_mode)
            MODE_SENDING:
            begin
                if (rotate_iv != 0)
                begin
                    elapsed  = 0;
                    ctl_mode = MODE_ROTATING;
                end
                else if (blink_iv != 0)
                begin
                    elapsed  = 0;
                    ctl_mode = MODE_BLINK_ON;
                end
                else
                    ctl_mode = MODE_DONE;
                return 1;
            end
            MODE_ROTATING:
            begin
                if (rotate_iv == 0)
                begin
                    ctl_mode = MODE_DONE;
                    return 0;
                end
                if (elapsed >= rotate_iv)
                begin
                    ctl_offset = (ctl_offset + 1) % NUM_LEDS;
                    elapsed    = 0;
                    return 1;
                end
                return 0;
            end
            MODE_BLINK_ON:
            begin
                if (elapsed >= blink_iv)
                begin
                    ctl_blank = 1;
                    elapsed   = 0;
                    ctl_mode  = MODE_BLINK_OFF;
                    return 1;
                end
                return 0;
            end
            MODE_BLINK_OFF:
            begin
                if (elapsed >= blink_iv)
                    ctl_mode = MODE_RELOAD;
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void apply_command(cmd_t c, logic [7:0] d, logic [15:0] iv,
                                          logic [9:0] pos);
        result_t r;
        mode_t   m;
        m        = ctl_mode;
        r.shown  = 1'b0;
        r.rd     = 8'h00;
        live_items++;
        case (c)
            CMD_START:
            begin
                ctl_fill   = 0;
                ctl_offset = 0;
                ctl_blank  = 0;
                ctl_mode   = MODE_LOADING;
            end
            CMD_FEED:
                if (m == MODE_LOADING && ctl_fill < FRAME_BYTES)
                begin
                    frame_copy[ctl_fill] = d;
                    ctl_fill++;
                end
            CMD_FINISH:
                if (m == MODE_LOADING)
                    ctl_mode = MODE_SENDING;
            CMD_TICK:
                r.shown = run_tick();
            CMD_RESET_IDLE:
                ctl_mode = MODE_IDLE;
            CMD_SET_BLINK:
            begin
                blink_iv  = iv;
                rotate_iv = 0;
                if (iv != 0)
                begin
                    if (m == MODE_IDLE || m == MODE_DONE || m == MODE_ROTATING)
                    begin
                        elapsed  = 0;
                        ctl_mode = MODE_BLINK_ON;
                    end
                    else if (m == MODE_BLINK_OFF || m == MODE_RELOAD)
                        ctl_mode = MODE_RELOAD;
                end
                else if (m == MODE_BLINK_ON || m == MODE_BLINK_OFF || m == MODE_RELOAD)
                    ctl_mode = MODE_RELOAD;
            end
            CMD_SET_ROTATE:
            begin
                rotate_iv = iv;
                blink_iv  = 0;
                if (iv != 0)
                begin
                    if (m == MODE_IDLE || m == MODE_DONE || m == MODE_BLINK_ON ||
                        m == MODE_ROTATING)
                    begin
                        elapsed  = 0;
                        ctl_mode = MODE_ROTATING;
                    end
                    else if (m == MODE_BLINK_OFF || m == MODE_RELOAD)
                        ctl_mode = MODE_RELOAD;
                end
            end
            default:
                r.rd = displayed_byte(pos);
        endcase
        r.mode   = ctl_mode;
        r.done   = (ctl_mode == MODE_DONE);
        r.reload = (ctl_mode == MODE_RELOAD);
        pending_results.push_back(r);
    endfunction

    // arg is the byte for feed, the interval for set, the position for read;
    // fields the command does not use carry random values
    task automatic send_cmd(cmd_t c, logic [15:0] arg = '0);
        logic [7:0]  d;
        logic [15:0] iv;
        logic [9:0]  pos;
        d   = (c == CMD_FEED) ? arg[7:0] : 8'($urandom);
        iv  = (c == CMD_SET_BLINK || c == CMD_SET_ROTATE) ? arg : 16'($urandom);
        pos = (c == CMD_READ) ? arg[9:0] : 10'($urandom);
        if ($urandom_range(99) < gap_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        command     <= c;
        data_byte   <= d;
        period_ms   <= iv;
        position    <= pos;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        apply_command(c, d, iv, pos);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [15:0] random_interval();
        return ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    endfunction

    function automatic logic [15:0] random_position();
        return ($urandom_range(3) == 0) ? 16'($urandom_range(0, 1023))
                                        : 16'($urandom_range(0, ctl_fill + 5));
    endfunction

    task automatic test_idle_commands();
        gap_pct   = 25;
        stall_pct = 25;
        send_cmd(CMD_FEED, 16'h00FF);
        send_cmd(CMD_FINISH);
        send_cmd(CMD_TICK);
        send_cmd(CMD_READ, 16'd0);
        send_cmd(CMD_SET_BLINK, 16'd0);
        send_cmd(CMD_RESET_IDLE);
    endtask

    task automatic test_load_and_read();
        send_cmd(CMD_START);
        send_cmd(CMD_FEED, 16'h0000);
        send_cmd(CMD_FEED, 16'h00FF);
        send_cmd(CMD_FEED, 16'h005A);
        send_cmd(CMD_READ, 16'd0);
        send_cmd(CMD_READ, 16'd1);
        send_cmd(CMD_READ, 16'd3);
        send_cmd(CMD_READ, 16'(FRAME_BYTES - 1));
        send_cmd(CMD_READ, 16'(FRAME_BYTES));
        send_cmd(CMD_READ, 16'h03FF);
        send_cmd(CMD_FINISH);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
    endtask

    task automatic test_rotate_rules();
        send_cmd(CMD_SET_ROTATE, 16'hFFFF);
        send_cmd(CMD_TICK);
        // zero period while rotating: next tick ends in done
        send_cmd(CMD_SET_ROTATE, 16'd0);
        send_cmd(CMD_TICK);
        send_cmd(CMD_START);
        repeat (6) send_cmd(CMD_FEED, 16'($urandom));
        send_cmd(CMD_SET_ROTATE, 16'd1);
        send_cmd(CMD_FINISH);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_READ, 16'd0);
        send_cmd(CMD_READ, 16'(FRAME_BYTES - 3));
        send_cmd(CMD_SET_BLINK, 16'd3);
        send_cmd(CMD_SET_ROTATE, 16'd2);
        send_cmd(CMD_RESET_IDLE);
    endtask

    task automatic test_blink_rules();
        send_cmd(CMD_START);
        repeat (6) send_cmd(CMD_FEED, 16'($urandom));
        send_cmd(CMD_SET_BLINK, 16'd2);
        send_cmd(CMD_FINISH);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_READ, 16'd0);
        wait_drained();
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_SET_BLINK, 16'd5);
        send_cmd(CMD_SET_ROTATE, 16'd4);
        send_cmd(CMD_SET_BLINK, 16'd0);
        send_cmd(CMD_TICK);
        send_cmd(CMD_START);
        send_cmd(CMD_FINISH);
        send_cmd(CMD_TICK);
        // zero blink period while blink on: wait met on the next tick
        send_cmd(CMD_SET_BLINK, 16'd7);
        send_cmd(CMD_SET_ROTATE, 16'd0);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_RESET_IDLE);
    endtask

    // fill past the end, then rotate one LED per tick through a full wrap
    task automatic test_full_frame_rotation();
        gap_pct   = 15;
        stall_pct = 15;
        send_cmd(CMD_START);
        for (int i = 0; i < FRAME_BYTES + 4; i++)
            send_cmd(CMD_FEED, 16'($urandom));
        send_cmd(CMD_READ, 16'd0);
        send_cmd(CMD_READ, 16'(FRAME_BYTES - 1));
        send_cmd(CMD_SET_ROTATE, 16'd1);
        send_cmd(CMD_FINISH);
        for (int i = 0; i < NUM_LEDS + 3; i++)
        begin
            send_cmd(CMD_TICK);
            if ($urandom_range(2) == 0)
                send_cmd(CMD_READ, 16'($urandom_range(0, FRAME_BYTES - 1)));
        end
        send_cmd(CMD_RESET_IDLE);
    endtask

    task automatic run_frame_sequence();
        int n_bytes;
        int n_steps;
        int pick;
        n_bytes = $urandom_range(0, 40);
        n_steps = $urandom_range(0, 25);
        if ($urandom_range(3) == 0)
            send_cmd($urandom_range(1) ? CMD_SET_BLINK : CMD_SET_ROTATE, random_interval());
        send_cmd(CMD_START);
        repeat (n_bytes)
        begin
            send_cmd(CMD_FEED, 16'($urandom));
            if ($urandom_range(7) == 0)
                send_cmd(CMD_READ, random_position());
        end
        case ($urandom_range(3))
            0: send_cmd(CMD_SET_BLINK, random_interval());
            1: send_cmd(CMD_SET_ROTATE, random_interval());
            default: ;
        endcase
        if ($urandom_range(9) != 0)
            send_cmd(CMD_FINISH);
        repeat (n_steps)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_cmd(CMD_TICK);
            else if (pick < 82)
                send_cmd(CMD_READ, random_position());
            else if (pick < 89)
                send_cmd(CMD_SET_BLINK, random_interval());
            else if (pick < 96)
                send_cmd(CMD_SET_ROTATE, random_interval());
            else if (pick < 98)
                send_cmd(CMD_RESET_IDLE);
            else
                send_cmd(CMD_FEED, 16'($urandom));
        end
    endtask

    task automatic test_random_mix(int target);
        int goal;
        goal = live_items + target;
        while (live_items < goal)
        begin
            if (goal - live_items < 200)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 20 * $urandom_range(2);
                stall_pct = 20 * $urandom_range(2);
            end
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(1, 8))
                    send_cmd(cmd_t'($urandom_range(7)), 16'($urandom));
            else
                run_frame_sequence();
            if ($urandom_range(19) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_commands();
        test_load_and_read();
        test_rotate_rules();
        test_blink_rules();
        test_full_frame_rotation();
        test_random_mix(ITEM_TARGET - live_items);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("** led_frame_rotate_blink_controller: PASSED **");
        else
            $display("** led_frame_rotate_blink_controller: FAILED **");
        $finish;
    end

    // result side stalls in short bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(99) < stall_pct)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            res_ready <= 1'b1;
        end
    end

    function automatic void flag_mismatch(string what, logic [15:0] want, logic [15:0] got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("[%0t] result beat %0d, %s: expected %0h, got %0h",
                     $time, result_beats, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("beat with nothing pending", 16'h0, 16'h1);
            else
            begin
                want = pending_results.pop_front();
                if (mode !== want.mode)
                    flag_mismatch("mode", 16'(want.mode), 16'(mode));
                if (frame_shown !== want.shown)
                    flag_mismatch("frame_shown", 16'(want.shown), 16'(frame_shown));
                if (read_data !== want.rd)
                    flag_mismatch("read_data", 16'(want.rd), 16'(read_data));
                if (is_done !== want.done)
                    flag_mismatch("is_done", 16'(want.done), 16'(is_done));
                if (reload_needed !== want.reload)
                    flag_mismatch("reload_needed", 16'(want.reload), 16'(reload_needed));
            end
            result_beats++;
        end
    end

    // ends the run if neither channel moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("** led_frame_rotate_blink_controller: FAILED **");
                $finish;
            end
        end
    end

endmodule
